// ===== rtl/core/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

	// Codes of the color_mode register.
	localparam logic [1:0] MODE_RAINBOW  = 2'd0;
	localparam logic [1:0] MODE_SPECTRUM = 2'd1;
	localparam logic [1:0] MODE_HEAT     = 2'd2;

	// Fixed scale factors; the _P1 ones are already incremented by one as the scaling multiply needs.
	localparam logic [8:0] RB_THIRD_P1 = 9'((256 / 3) + 1);
	localparam logic [8:0] RB_TWO_P1   = 9'(((256 * 2) / 3) + 1);
	localparam logic [8:0] SPEC_SPAN_P1 = 9'(191 + 1);
	localparam logic [7:0] HEAT_SPAN   = 8'd191;

	typedef enum logic [1:0] {
		KIND_RAINBOW,
		KIND_SPECTRUM,
		KIND_HEAT
	} kind_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] brightness_value;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// One classified item as it waits between the front and the back.
	typedef struct packed {
		kind_t      kind;
		rgb_t       base;
		logic       sat_full;
		logic       sat_zero;
		logic [7:0] desat;
		logic [7:0] keep;
		logic       val_full;
		logic [7:0] val_sq;
		logic [7:0] spec_h;
		logic [7:0] floor_v;
		logic [7:0] amp;
		logic [7:0] heat_t;
	} entry_t;

endpackage

// ===== rtl/core/hsvrgb_front.sv =====
module hsvrgb_front
	import hsvrgb_pkg::*;
(
	input  logic       push,
	input  logic       full,
	input  logic [1:0] mode,
	input  hsv_t       hsv,
	output logic       wr_en,
	output entry_t     entry
);

	logic [7:0]  off8;
	logic [16:0] prod_third;
	logic [16:0] prod_two;
	logic [7:0]  third;
	logic [7:0]  two;
	logic [7:0]  inv_sat;
	logic [15:0] desat_prod;
	logic [15:0] val_prod;
	logic [16:0] spec_prod;
	logic [15:0] floor_prod;
	logic [15:0] heat_prod;

	assign wr_en = push && !full;

	always_comb begin
		off8       = {hsv.hue[4:0], 3'b000};
		prod_third = 17'(off8) * 17'(RB_THIRD_P1);
		prod_two   = 17'(off8) * 17'(RB_TWO_P1);
		third      = prod_third[15:8];
		two        = prod_two[15:8];

		unique case (mode)
			MODE_RAINBOW:  entry.kind = KIND_RAINBOW;
			MODE_SPECTRUM: entry.kind = KIND_SPECTRUM;
			default:       entry.kind = KIND_HEAT;
		endcase

		// Eight hue sections with a moderate boost through yellow.
		unique case (hsv.hue[7:5])
			3'd0: entry.base = '{8'd255 - third, third, 8'd0};
			3'd1: entry.base = '{8'd171, 8'd85 + third, 8'd0};
			3'd2: entry.base = '{8'd171 - two, 8'd170 + third, 8'd0};
			3'd3: entry.base = '{8'd0, 8'd255 - third, third};
			3'd4: entry.base = '{8'd0, 8'd171 - two, 8'd85 + two};
			3'd5: entry.base = '{third, 8'd0, 8'd255 - third};
			3'd6: entry.base = '{8'd85 + third, 8'd0, 8'd171 - third};
			default: entry.base = '{8'd170 + third, 8'd0, 8'd85 - third};
		endcase

		inv_sat        = 8'hFF - hsv.saturation;
		desat_prod     = 16'(inv_sat) * 16'(inv_sat);
		entry.desat    = desat_prod[15:8] + {7'd0, inv_sat != 8'd0};
		entry.keep     = 8'hFF - entry.desat;
		entry.sat_full = hsv.saturation == 8'hFF;
		entry.sat_zero = hsv.saturation == 8'h00;

		val_prod       = 16'(hsv.brightness_value) * 16'(hsv.brightness_value);
		entry.val_sq   = val_prod[15:8] + {7'd0, hsv.brightness_value != 8'd0};
		entry.val_full = hsv.brightness_value == 8'hFF;

		spec_prod      = 17'(hsv.hue) * 17'(SPEC_SPAN_P1);
		entry.spec_h   = spec_prod[15:8];
		floor_prod     = 16'(hsv.brightness_value) * 16'(inv_sat);
		entry.floor_v  = floor_prod[15:8];
		entry.amp      = hsv.brightness_value - entry.floor_v;

		heat_prod      = 16'(hsv.hue) * 16'(HEAT_SPAN);
		entry.heat_t   = heat_prod[15:8] + {7'd0, hsv.hue != 8'd0};
	end

endmodule

// ===== rtl/core/hsvrgb_queue.sv =====
module hsvrgb_queue
	import hsvrgb_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	input  logic   rd_en,
	output entry_t rd_data,
	output logic   full,
	output logic   q_empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue empty with pointers apart");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a write");

endmodule

// ===== rtl/core/hsvrgb_back.sv =====
module hsvrgb_back
	import hsvrgb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	input  entry_t q_entry,
	output logic   q_pop,
	output logic   empty,
	input  logic   pop,
	output rgb_t   rgb
);

	logic       valid_s1;
	rgb_t       rgb_s1;
	logic       scale_s1;
	logic [7:0] val_sq_s1;
	logic       valid_s2;
	rgb_t       rgb_s2;

	logic        ready_s1;
	logic        ready_s2;
	logic [8:0]  keep_p1;
	logic [16:0] rb_prod_r;
	logic [16:0] rb_prod_g;
	logic [16:0] rb_prod_b;
	rgb_t        rb_rgb;
	logic [5:0]  up;
	logic [5:0]  down;
	logic [13:0] up_prod;
	logic [13:0] down_prod;
	logic [7:0]  up_f;
	logic [7:0]  down_f;
	logic [7:0]  ramp;
	rgb_t        next_s1;
	logic [8:0]  val_p1;
	logic [16:0] vs_prod_r;
	logic [16:0] vs_prod_g;
	logic [16:0] vs_prod_b;
	rgb_t        next_s2;

	assign ready_s2 = !valid_s2 || pop;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign q_pop    = ready_s1 && !q_empty;
	assign empty    = !valid_s2;
	assign rgb      = rgb_s2;

	// First back stage: desaturation floor, spectrum ramps, heat ramp.
	always_comb begin
		keep_p1   = {1'b0, q_entry.keep} + 9'd1;
		rb_prod_r = 17'(q_entry.base.red) * 17'(keep_p1);
		rb_prod_g = 17'(q_entry.base.green) * 17'(keep_p1);
		rb_prod_b = 17'(q_entry.base.blue) * 17'(keep_p1);
		if (q_entry.sat_full) begin
			rb_rgb = q_entry.base;
		end else if (q_entry.sat_zero) begin
			rb_rgb = '{8'hFF, 8'hFF, 8'hFF};
		end else begin
			rb_rgb = '{rb_prod_r[15:8] + q_entry.desat, rb_prod_g[15:8] + q_entry.desat,
				rb_prod_b[15:8] + q_entry.desat};
		end

		up        = q_entry.spec_h[5:0];
		down      = 6'h3F - up;
		up_prod   = 14'(up) * 14'(q_entry.amp);
		down_prod = 14'(down) * 14'(q_entry.amp);
		up_f      = up_prod[13:6] + q_entry.floor_v;
		down_f    = down_prod[13:6] + q_entry.floor_v;

		ramp = {q_entry.heat_t[5:0], 2'b00};

		unique case (q_entry.kind)
			KIND_RAINBOW: next_s1 = rb_rgb;
			KIND_SPECTRUM: begin
				case (q_entry.spec_h[7:6])
					2'd0:    next_s1 = '{down_f, up_f, q_entry.floor_v};
					2'd1:    next_s1 = '{q_entry.floor_v, down_f, up_f};
					default: next_s1 = '{up_f, q_entry.floor_v, down_f};
				endcase
			end
			default: begin
				if (q_entry.heat_t[7]) begin
					next_s1 = '{8'hFF, 8'hFF, ramp};
				end else if (q_entry.heat_t[6]) begin
					next_s1 = '{8'hFF, ramp, 8'h00};
				end else begin
					next_s1 = '{ramp, 8'h00, 8'h00};
				end
			end
		endcase
	end

	// Second back stage: squared value scaling, used by rainbow items only.
	always_comb begin
		val_p1    = {1'b0, val_sq_s1} + 9'd1;
		vs_prod_r = 17'(rgb_s1.red) * 17'(val_p1);
		vs_prod_g = 17'(rgb_s1.green) * 17'(val_p1);
		vs_prod_b = 17'(rgb_s1.blue) * 17'(val_p1);
		if (!scale_s1) begin
			next_s2 = rgb_s1;
		end else if (val_sq_s1 == 8'd0) begin
			next_s2 = '{8'h00, 8'h00, 8'h00};
		end else begin
			next_s2 = '{vs_prod_r[15:8], vs_prod_g[15:8], vs_prod_b[15:8]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= !q_empty;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rgb_s1    <= next_s1;
			scale_s1  <= (q_entry.kind == KIND_RAINBOW) && !q_entry.val_full;
			val_sq_s1 <= q_entry.val_sq;
		end
		if (ready_s2 && valid_s1) begin
			rgb_s2 <= next_s2;
		end
	end

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> valid_s1)
		else $error("item taken from the queue did not reach the first stage");

endmodule

// ===== rtl/core/hsv_to_rgb_color_converter_core.sv =====
// HSV to RGB color converter, 8 bits per channel.
// Input channel: an hsv item (hue, saturation, brightness_value) is taken at a
// rising edge with push high and full low. Result channel: while empty is low the
// oldest rgb item is on rgb and is taken at a rising edge with pop high.
// Configuration: cfg_data carries color_mode (rainbow, spectrum, heat; the unused
// code behaves as heat). It is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high. The mode is sampled as each item enters.
// Throughput is one item per clock while the receiver keeps popping. An item taken
// in passes the queue, the first back stage and the output register: the front
// classifies and does the first multiplies on the way into the queue, then two back
// stages each do one row of multiplies before the output register.
// When the receiver stalls, the output register and first back stage hold their
// items, the queue between front and back fills, and full rises once its
// QUEUE_DEPTH entries are taken; up to QUEUE_DEPTH + 2 items are buffered.
// Reset clears the mode to rainbow and empties the queue and both back stages.
module hsv_to_rgb_color_converter_core
	import hsvrgb_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  hsv_t       hsv,
	output logic       empty,
	input  logic       pop,
	output rgb_t       rgb,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_data
);

	logic [1:0] mode_q;
	logic       wr_en;
	entry_t     wr_entry;
	entry_t     rd_entry;
	logic       q_pop;
	logic       q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAINBOW;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	hsvrgb_front u_front (
		.push  (push),
		.full  (full),
		.mode  (mode_q),
		.hsv   (hsv),
		.wr_en (wr_en),
		.entry (wr_entry)
	);

	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_entry),
		.rd_en   (q_pop),
		.rd_data (rd_entry),
		.full    (full),
		.q_empty (q_empty)
	);

	hsvrgb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.rgb     (rgb)
	);

endmodule

// ===== dv/rgb_result_check.sv =====
`timescale 1ns / 1ps
module rgb_result_check
	import hsvrgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  hsv_t       hsv,
	input  logic       empty,
	input  logic       pop,
	input  rgb_t       rgb,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_data,
	output int         pending,
	output int         fail_count
);

	localparam int unsigned THIRD       = 256 / 3;
	localparam int unsigned TWO_THIRDS  = (256 * 2) / 3;
	localparam int unsigned SPEC_SPAN   = 191;
	localparam int unsigned HEAT_SPAN   = 191;

	logic [1:0] color_mode;
	rgb_t       rgb_due[$];

	// Multiply by s + 1 and keep the high byte.
	function automatic int unsigned scale_p1(int unsigned i, int unsigned s);
		return ((i & 255) * ((s & 255) + 1)) >> 8;
	endfunction

	// Multiply and keep the high byte, adding one whenever the product is nonzero.
	function automatic int unsigned scale_video(int unsigned i, int unsigned s);
		int unsigned a;
		int unsigned b;
		a = i & 255;
		b = s & 255;
		return ((a * b) >> 8) + ((a != 0 && b != 0) ? 1 : 0);
	endfunction

	function automatic rgb_t rainbow_rgb(hsv_t c);
		int unsigned off8, third, two, r, g, b, desat, keep, v;
		rgb_t res;
		off8 = {c.hue[4:0], 3'b000};
		third = scale_p1(off8, THIRD);
		two = scale_p1(off8, TWO_THIRDS);
		case (c.hue[7:5])
			3'd0: begin r = 255 - third; g = third; b = 0; end
			3'd1: begin r = 171; g = 85 + third; b = 0; end
			3'd2: begin r = 171 - two; g = 170 + third; b = 0; end
			3'd3: begin r = 0; g = 255 - third; b = third; end
			3'd4: begin r = 0; g = 171 - two; b = 85 + two; end
			3'd5: begin r = third; g = 0; b = 255 - third; end
			3'd6: begin r = 85 + third; g = 0; b = 171 - third; end
			default: begin r = 170 + third; g = 0; b = 85 - third; end
		endcase
		if (c.saturation != 8'd255) begin
			if (c.saturation == 8'd0) begin
				r = 255; g = 255; b = 255;
			end else begin
				desat = scale_video(255 - c.saturation, 255 - c.saturation);
				keep = (255 - desat) & 255;
				r = (scale_p1(r, keep) + desat) & 255;
				g = (scale_p1(g, keep) + desat) & 255;
				b = (scale_p1(b, keep) + desat) & 255;
			end
		end
		if (c.brightness_value != 8'd255) begin
			v = scale_video(c.brightness_value, c.brightness_value) & 255;
			if (v == 0) begin
				r = 0; g = 0; b = 0;
			end else begin
				r = scale_p1(r, v);
				g = scale_p1(g, v);
				b = scale_p1(b, v);
			end
		end
		res.red = 8'(r);
		res.green = 8'(g);
		res.blue = 8'(b);
		return res;
	endfunction

	function automatic rgb_t spectrum_rgb(hsv_t c);
		int unsigned h, floor_v, amp, up, down, up_f, down_f;
		rgb_t res;
		h = scale_p1(c.hue, SPEC_SPAN);
		floor_v = (c.brightness_value * (255 - c.saturation)) >> 8;
		amp = c.brightness_value - floor_v;
		up = h & 63;
		down = 63 - up;
		up_f = (((up * amp) >> 6) + floor_v) & 255;
		down_f = (((down * amp) >> 6) + floor_v) & 255;
		case (h >> 6)
			0: res = '{8'(down_f), 8'(up_f), 8'(floor_v)};
			1: res = '{8'(floor_v), 8'(down_f), 8'(up_f)};
			default: res = '{8'(up_f), 8'(floor_v), 8'(down_f)};
		endcase
		return res;
	endfunction

	// Saturation and value play no part on the temperature ramp.
	function automatic rgb_t heat_rgb(logic [7:0] temp);
		logic [7:0] t;
		logic [7:0] ramp;
		rgb_t res;
		t = 8'(scale_video(temp, HEAT_SPAN));
		ramp = {t[5:0], 2'b00};
		if (t[7])
			res = '{8'd255, 8'd255, ramp};
		else if (t[6])
			res = '{8'd255, ramp, 8'd0};
		else
			res = '{ramp, 8'd0, 8'd0};
		return res;
	endfunction

	function automatic rgb_t convert_hsv(logic [1:0] mode, hsv_t c);
		case (mode)
			MODE_RAINBOW:  return rainbow_rgb(c);
			MODE_SPECTRUM: return spectrum_rgb(c);
			default:       return heat_rgb(c.hue);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rgb_t want;
		if (!arst_n) begin
			color_mode = MODE_RAINBOW;
			rgb_due.delete();
			pending = 0;
			fail_count = 0;
		end else begin
			// Results are checked before new items are predicted, and the mode is
			// taken as it stood when each item entered.
			if (pop && !empty) begin
				if (rgb_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected rgb item, expected none, got %0d/%0d/%0d",
						$time, rgb.red, rgb.green, rgb.blue);
				end else begin
					want = rgb_due.pop_front();
					if (want.red !== rgb.red || want.green !== rgb.green ||
							want.blue !== rgb.blue) begin
						fail_count++;
						$display("%0t: rgb mismatch, expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$time, want.red, want.green, want.blue,
							rgb.red, rgb.green, rgb.blue);
					end
				end
			end
			if (push && !full)
				rgb_due.push_back(convert_hsv(color_mode, hsv));
			if (cfg_valid && cfg_ready)
				color_mode = cfg_data;
			pending = rgb_due.size();
		end
	end

endmodule

// ===== dv/tb_hsv_to_rgb_color_converter_core.sv =====
`timescale 1ns / 1ps
module tb_hsv_to_rgb_color_converter_core;
	import hsvrgb_pkg::*;

	// The unused mode code, which the block treats as heat.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int ITEMS_PER_PHASE = 225;
	localparam int PHASES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	hsv_t       hsv = '0;
	logic       pop = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [1:0] cfg_data = MODE_RAINBOW;
	logic       full;
	logic       empty;
	logic       cfg_ready;
	rgb_t       rgb;
	int         pending;
	int         fail_count;
	logic       steady = 1'b0;

	always #5 clk = ~clk;

	hsv_to_rgb_color_converter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.hsv       (hsv),
		.empty     (empty),
		.pop       (pop),
		.rgb       (rgb),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	rgb_result_check result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.hsv        (hsv),
		.empty      (empty),
		.pop        (pop),
		.rgb        (rgb),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// The receiver stalls about 19 percent of the time, except during the steady phase.
	always @(posedge clk) begin
		pop <= arst_n && (steady || $urandom_range(99) >= 19);
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return $urandom_range(1) ? 8'd1 : 8'd254;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic hsv_t random_hsv();
		hsv_t c;
		c.hue = pick_byte();
		c.saturation = pick_byte();
		c.brightness_value = pick_byte();
		return c;
	endfunction

	task automatic send_hsv(hsv_t item);
		while (!steady && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		hsv <= item;
		do @(posedge clk); while (full);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// The mode only changes once every item in flight has come out.
	task automatic write_mode(logic [1:0] mode);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		hsv_t       directed [8];
		logic [1:0] phase_mode [PHASES];
		logic [1:0] main_mode [3];
		directed[0] = '{8'd0, 8'd255, 8'd255};
		directed[1] = '{8'd255, 8'd255, 8'd255};
		directed[2] = '{8'd31, 8'd0, 8'd255};
		directed[3] = '{8'd32, 8'd1, 8'd1};
		directed[4] = '{8'd96, 8'd128, 8'd0};
		directed[5] = '{8'd160, 8'd254, 8'd254};
		directed[6] = '{8'd224, 8'd255, 8'd128};
		directed[7] = '{8'd191, 8'd2, 8'd255};
		main_mode[0] = MODE_RAINBOW;
		main_mode[1] = MODE_SPECTRUM;
		main_mode[2] = MODE_HEAT;
		phase_mode[0] = MODE_RAINBOW;
		phase_mode[1] = MODE_SPECTRUM;
		phase_mode[2] = MODE_RAINBOW;
		phase_mode[3] = MODE_HEAT;
		phase_mode[4] = MODE_SPARE;
		phase_mode[5] = MODE_SPECTRUM;
		phase_mode[6] = MODE_RAINBOW;
		phase_mode[7] = MODE_HEAT;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int m = 0; m < 3; m++) begin
			write_mode(main_mode[m]);
			for (int k = 0; k < 8; k++)
				send_hsv(directed[k]);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_mode(phase_mode[p]);
			steady <= (p == 2);
			repeat (ITEMS_PER_PHASE) send_hsv(random_hsv());
		end
		steady <= 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_front.sv
rtl/core/hsvrgb_queue.sv
rtl/core/hsvrgb_back.sv
rtl/core/hsv_to_rgb_color_converter_core.sv
dv/rgb_result_check.sv
dv/tb_hsv_to_rgb_color_converter_core.sv
